// File: hdl/tsgc_pkg.sv
package tsgc_pkg;

	localparam int TIME_W = 32;
	localparam int AMP_W = 16;
	localparam int INV_W = 32;
	localparam int COV_W = 34;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int TERM_W = 32;
	localparam int A2_W = 2 * AMP_W;
	localparam int U_W = 20;
	localparam int FRAC_W = 16;
	localparam int TAB_W = 17;
	localparam int DEF_EXP_TABLE_DEPTH = 256;
	localparam int LATENCY = 8;

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(256);
	localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);
	localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_FIRST = 2'd0,
		REG_INV_SCALE_FIRST = 2'd1,
		REG_AMP_SECOND = 2'd2,
		REG_INV_SCALE_SECOND = 2'd3
	} cfg_reg_t;

endpackage

// File: hdl/tsgc_if.sv
interface tsgc_req_if;
	import tsgc_pkg::*;
	logic valid;
	logic ready;
	logic signed [TIME_W-1:0] time_row;
	logic signed [TIME_W-1:0] time_col;
	modport source (output valid, output time_row, output time_col, input ready);
	modport sink (input valid, input time_row, input time_col, output ready);
endinterface

interface tsgc_rsp_if;
	import tsgc_pkg::*;
	logic valid;
	logic ready;
	logic [COV_W-1:0] covariance;
	modport source (output valid, output covariance, input ready);
	modport sink (input valid, input covariance, output ready);
endinterface

// File: hdl/tsgc_term.sv
module tsgc_term #(
	parameter int EXP_TABLE_DEPTH = tsgc_pkg::DEF_EXP_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [tsgc_pkg::TIME_W-1:0]      dist_s1,
	input  logic [tsgc_pkg::INV_W-1:0]       inv_scale,
	input  logic [tsgc_pkg::A2_W-1:0]        amp_sq,
	output logic [tsgc_pkg::TERM_W-1:0]      term_s7
);
	import tsgc_pkg::*;

	localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int POS_W = U_W + TW;
	localparam logic [63:0] STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;

	typedef logic [TAB_W-1:0] tab_t [EXP_TABLE_DEPTH+1];

	function automatic tab_t build_tab();
		tab_t t;
		logic [63:0] plus;
		logic [63:0] minus;
		logic [63:0] trm;
		logic [63:0] r;
		logic [63:0] e;
		plus = 64'd1 << 30;
		minus = 64'd0;
		trm = 64'd1 << 30;
		for (int n = 1; n <= 40; n++) begin
			if (trm != 64'd0) begin
				trm = (trm * STEP) / 64'(n);
				if (n % 2 == 1) minus = minus + trm;
				else plus = plus + trm;
			end
		end
		r = (plus > minus) ? plus - minus : 64'd0;
		e = 64'd1 << 30;
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			t[k] = TAB_W'((e + (64'd1 << 13)) >> 14);
			e = (e * r + (64'd1 << 29)) >> 30;
		end
		return t;
	endfunction

	localparam tab_t EXP_TAB = build_tab();

	logic [63:0]        prod_p;
	logic [2*U_W-1:0]   prod_sq;
	logic [POS_W-1:0]   prod_pos;
	logic [TW-1:0]      idx_lo;
	logic [TW-1:0]      idx_hi;
	logic [2*FRAC_W:0]  prod_lerp;
	logic [A2_W+TAB_W-1:0] prod_amp;

	logic               oob_s2, oob_s3, oob_s4, oob_s5, oob_s6;
	logic [U_W-1:0]     u_s2, x_s3;
	logic [IW-1:0]      idx_s4;
	logic [FRAC_W-1:0]  frac_s4, frac_s5;
	logic [TAB_W-1:0]   t0_s5, dt_s5, e_s6;

	assign prod_p = 64'(dist_s1) * 64'(inv_scale);
	assign prod_sq = u_s2 * u_s2;
	assign prod_pos = POS_W'(x_s3) * POS_W'(EXP_TABLE_DEPTH);
	assign idx_lo = TW'(idx_s4);
	assign idx_hi = TW'(idx_s4) + TW'(1);
	assign prod_lerp = dt_s5 * frac_s5;
	assign prod_amp = amp_sq * e_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s2 <= |prod_p[63:36];
			u_s2 <= prod_p[35:16];
			oob_s3 <= oob_s2 | (|prod_sq[39:37]);
			x_s3 <= prod_sq[36:17];
			oob_s4 <= oob_s3;
			idx_s4 <= prod_pos[U_W+IW-1:U_W];
			frac_s4 <= prod_pos[U_W-1:4];
			oob_s5 <= oob_s4;
			frac_s5 <= frac_s4;
			t0_s5 <= EXP_TAB[idx_lo];
			dt_s5 <= EXP_TAB[idx_lo] - EXP_TAB[idx_hi];
			oob_s6 <= oob_s5;
			e_s6 <= t0_s5 - TAB_W'(prod_lerp >> FRAC_W);
			term_s7 <= oob_s6 ? '0 : prod_amp[47:16];
		end
	end

endmodule

// File: hdl/two_scale_gaussian_covariance_top.sv
// Streams one covariance entry per clock: each request (a pair of sample times) yields
// amp^2*exp(-0.5*(dt*inv_scale)^2) summed over two components, unsigned Q18.16. The
// eight stages are the time difference, a 32x32 multiply by the inverse scale, the
// square, the table position, the exp table read, the linear interpolation, the
// amplitude multiply and the final sum. A stall at the output holds the whole pipeline;
// requests are taken whenever the last stage is empty or drained.
// Configuration writes are registered (amplitude then squared) and belong to an idle block.
module two_scale_gaussian_covariance_top #(
	parameter int EXP_TABLE_DEPTH = tsgc_pkg::DEF_EXP_TABLE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsgc_pkg::CFG_DATA_W-1:0]   cfg_data,
	tsgc_req_if.sink                          req,
	tsgc_rsp_if.source                        rsp
);
	import tsgc_pkg::*;

	logic [AMP_W-1:0]  amp_first_q, amp_second_q;
	logic [INV_W-1:0]  inv_first_q, inv_second_q;
	logic [A2_W-1:0]   a2_first_q, a2_second_q;
	logic [LATENCY-1:0] vld_q;
	logic              en;
	logic signed [TIME_W:0] diff;
	logic [TIME_W-1:0] dist_s1;
	logic [TERM_W-1:0] term_a_s7, term_b_s7;
	logic [COV_W-1:0]  sum;
	logic [COV_W-1:0]  cov_s8;

	assign en = !vld_q[LATENCY-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[LATENCY-1];
	assign rsp.covariance = cov_s8;

	assign diff = (TIME_W+1)'(req.time_row) - (TIME_W+1)'(req.time_col);
	assign sum = COV_W'(term_a_s7) + COV_W'(term_b_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_first_q <= AMP_RESET;
			inv_first_q <= INV_RESET;
			amp_second_q <= AMP_RESET;
			inv_second_q <= INV_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMP_FIRST: amp_first_q <= cfg_data[AMP_W-1:0];
				REG_INV_SCALE_FIRST: inv_first_q <= cfg_data[INV_W-1:0];
				REG_AMP_SECOND: amp_second_q <= cfg_data[AMP_W-1:0];
				REG_INV_SCALE_SECOND: inv_second_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a2_first_q <= A2_W'(amp_first_q) * A2_W'(amp_first_q);
		a2_second_q <= A2_W'(amp_second_q) * A2_W'(amp_second_q);
	end

	// valid bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= diff[TIME_W] ? TIME_W'(-diff) : diff[TIME_W-1:0];
			cov_s8 <= (sum > COV_MAX) ? COV_MAX : sum;
		end
	end

	tsgc_term #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_term_first (
		.clk       (clk),
		.en        (en),
		.dist_s1   (dist_s1),
		.inv_scale (inv_first_q),
		.amp_sq    (a2_first_q),
		.term_s7   (term_a_s7)
	);

	tsgc_term #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_term_second (
		.clk       (clk),
		.en        (en),
		.dist_s1   (dist_s1),
		.inv_scale (inv_second_q),
		.amp_sq    (a2_second_q),
		.term_s7   (term_b_s7)
	);

endmodule
